[rtl/cpf_pkg.sv]
// cpf_pkg: shared codes and constants for the convex polygon fill unit.
// No dependencies.
package cpf_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int MIN_VERTICES = 3;
  localparam int CNT_BITS     = 5;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_EMUL1 = 14'b00000000000010,
    ST_EMUL2 = 14'b00000000000100,
    ST_EMUL3 = 14'b00000000001000,
    ST_EWR   = 14'b00000000010000,
    ST_RD    = 14'b00000000100000,
    ST_TMUL1 = 14'b00000001000000,
    ST_TMUL2 = 14'b00000010000000,
    ST_TMUL3 = 14'b00000100000000,
    ST_TCHK  = 14'b00001000000000,
    ST_SMUL1 = 14'b00010000000000,
    ST_SMUL2 = 14'b00100000000000,
    ST_SDIV  = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } cpf_state_t;

endpackage

[rtl/cpf_divider.sv]
// cpf_divider: signed restoring divider, one quotient bit per cycle,
// quotient truncated toward zero. Uses cpf_pkg.
module cpf_divider import cpf_pkg::*; #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 13
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W:0]   quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag_r;
  logic [DEN_W-1:0] dmag_r;
  logic [DEN_W-1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             neg_r;
  logic             done_r;
  logic [DEN_W-1:0] shifted;
  logic             take;

  assign shifted = {rem_r[DEN_W-2:0], mag_r[NUM_W-1]};
  assign take    = (shifted >= dmag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
        neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
        mag_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag_r <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? DEN_W'(shifted - dmag_r) : shifted;
        mag_r <= {mag_r[NUM_W-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

endmodule

[rtl/convex_polygon_fill_and_point_test_unit.sv]
// Convex polygon loader, point-in-polygon tester and row span generator.
// Uses cpf_pkg and cpf_divider.
//
//  channel | direction | ports
//  in      | input     | in_valid/in_ready, in_kind, in_point_x, in_point_y
//  out     | output    | out_valid/out_ready, out_result_kind, out_inside_res,
//          |           | out_span_valid, out_span_left, out_span_right
//  cfg     | input     | cfg_valid/cfg_ready, cfg_vertex_count
//
// Vertex: the first is only stored; each later one writes an edge, the last
// also the closing edge. Point test: RD, TMUL1..3, TCHK per edge. Span query:
// RD, SMUL1 per edge, plus SMUL2, SDIV (shared divider) per sloped edge.
// One item at a time: in_ready is high only while the sequencer is idle.
// A waiting result holds the sequencer in its output state. Reset is
// synchronous; edge storage is not cleared.
module convex_polygon_fill_and_point_test_unit import cpf_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [COORD_BITS-1:0]        in_point_x,
  input  logic [COORD_BITS-1:0]        in_point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic                         out_inside_res,
  output logic                         out_span_valid,
  output logic signed [COORD_BITS:0]   out_span_left,
  output logic [COORD_BITS-1:0]        out_span_right,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CNT_BITS-1:0]          cfg_vertex_count
);

  localparam int C   = COORD_BITS;
  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int MW  = 2*C + 2;
  localparam int AW  = 2*C + 3;
  localparam int NW  = 2*C + 10;
  localparam int QW  = NW + 1;
  localparam int CNT_W = (VW > CNT_BITS) ? VW : CNT_BITS;

  typedef struct packed {
    logic signed [C:0]   a;
    logic signed [C:0]   b;
    logic signed [2*C:0] c;
    logic                left;
    logic [C-1:0]        lo;
    logic [C-1:0]        hi;
  } edge_t;

  edge_t edge_mem [MAX_VERTICES];
  edge_t rd_q;
  edge_t wr_d;

  cpf_state_t state_r, state_nxt;

  logic [CNT_BITS-1:0] vcount_r;
  logic [VW-1:0]       loaded_r;
  logic [VW-1:0]       n_eff;
  logic                closed;
  logic [C-1:0]        first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [C-1:0]        xmin_r, xmax_r, ymin_r, ymax_r;
  logic [C-1:0]        ex0_r, ey0_r, ex1_r, ey1_r;
  logic [C-1:0]        px_r, py_r;
  logic [IW-1:0]       idx_r, widx_r;
  logic                close_pend_r;
  logic                mode_r;
  logic                outside_r;
  logic                span_ok_r;
  logic signed [C:0]   mul_a, mul_b;
  logic signed [MW-1:0] mul_r;
  logic signed [AW-1:0] acc_r;
  logic signed [QW-1:0] lft_r, rgt_r;
  logic                div_start;
  logic                div_done;
  logic                div_started_r;
  logic signed [NW-1:0] div_num;
  logic signed [QW-1:0] div_quo;
  logic                last_edge;
  logic                out_valid_r;
  logic                res_kind_r, res_inside_r, res_valid_r;
  logic signed [C:0]   res_left_r;
  logic [C-1:0]        res_right_r;
  logic                out_free;
  logic signed [QW-1:0] lsum, rsum;
  logic [C-1:0]        lrnd, rrnd;

  always_comb begin
    if (CNT_W'(vcount_r) < CNT_W'(MIN_VERTICES)) n_eff = VW'(MIN_VERTICES);
    else if (CNT_W'(vcount_r) > CNT_W'(MAX_VERTICES)) n_eff = VW'(MAX_VERTICES);
    else n_eff = VW'(vcount_r);
  end

  assign closed    = (loaded_r >= n_eff);
  assign last_edge = (VW'(idx_r) == VW'(n_eff - 1'b1));
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign wr_d.a    = $signed({1'b0, ey0_r}) - $signed({1'b0, ey1_r});
  assign wr_d.b    = $signed({1'b0, ex1_r}) - $signed({1'b0, ex0_r});
  assign wr_d.c    = acc_r[2*C:0];
  assign wr_d.left = (ey0_r < ey1_r);
  assign wr_d.lo   = (ex0_r < ex1_r) ? ex0_r : ex1_r;
  assign wr_d.hi   = (ex0_r < ex1_r) ? ex1_r : ex0_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_EWR) edge_mem[widx_r] <= wr_d;
    rd_q <= edge_mem[idx_r];
  end

  always_comb begin
    case (state_r)
      ST_EMUL1: begin
        mul_a = $signed({1'b0, ex0_r});
        mul_b = $signed({1'b0, ey1_r});
      end
      ST_EMUL2: begin
        mul_a = $signed({1'b0, ex1_r});
        mul_b = $signed({1'b0, ey0_r});
      end
      ST_TMUL1: begin
        mul_a = rd_q.a;
        mul_b = $signed({1'b0, px_r});
      end
      default: begin
        mul_a = rd_q.b;
        mul_b = $signed({1'b0, py_r});
      end
    endcase
  end

  always_ff @(posedge clk) mul_r <= mul_a * mul_b;

  assign div_num   = {acc_r[2*C+1:0], {FRAC_BITS{1'b0}}};
  assign div_start = (state_r == ST_SDIV) && !div_started_r;

  cpf_divider #(.NUM_W(NW), .DEN_W(C+1)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (rd_q.a),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_POINT) begin
            if (closed) state_nxt = ST_RD;
            else if (loaded_r != '0) state_nxt = ST_EMUL1;
          end else begin
            if (!closed || in_point_y < ymin_r || in_point_y > ymax_r) state_nxt = ST_OUT;
            else state_nxt = ST_RD;
          end
        end
      end
      ST_EMUL1: state_nxt = ST_EMUL2;
      ST_EMUL2: state_nxt = ST_EMUL3;
      ST_EMUL3: state_nxt = ST_EWR;
      ST_EWR:   state_nxt = close_pend_r ? ST_EMUL1 : ST_IDLE;
      ST_RD:    state_nxt = (mode_r == KIND_POINT) ? ST_TMUL1 : ST_SMUL1;
      ST_TMUL1: state_nxt = ST_TMUL2;
      ST_TMUL2: state_nxt = ST_TMUL3;
      ST_TMUL3: state_nxt = ST_TCHK;
      ST_TCHK:  state_nxt = last_edge ? ST_OUT : ST_RD;
      ST_SMUL1: begin
        if (rd_q.a == '0) state_nxt = last_edge ? ST_OUT : ST_RD;
        else state_nxt = ST_SMUL2;
      end
      ST_SMUL2: state_nxt = ST_SDIV;
      ST_SDIV:  if (div_done) state_nxt = last_edge ? ST_OUT : ST_RD;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign lsum = lft_r + QW'(1 << (FRAC_BITS - 1));
  assign rsum = rgt_r + QW'(1 << (FRAC_BITS - 1));
  assign lrnd = lsum[C+FRAC_BITS-1:FRAC_BITS];
  assign rrnd = rsum[C+FRAC_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      vcount_r      <= CNT_BITS'(MIN_VERTICES);
      loaded_r      <= '0;
      first_x_r     <= '0;
      first_y_r     <= '0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      xmin_r        <= '0;
      xmax_r        <= '0;
      ymin_r        <= '0;
      ymax_r        <= '0;
      close_pend_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      div_started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            px_r  <= in_point_x;
            py_r  <= in_point_y;
            idx_r <= '0;
            mode_r <= in_kind;
            outside_r <= 1'b0;
            span_ok_r <= 1'b0;
            if (in_kind == KIND_POINT && !closed) begin
              prev_x_r <= in_point_x;
              prev_y_r <= in_point_y;
              loaded_r <= loaded_r + 1'b1;
              if (loaded_r == '0) begin
                first_x_r <= in_point_x;
                first_y_r <= in_point_y;
                xmin_r <= in_point_x;
                xmax_r <= in_point_x;
                ymin_r <= in_point_y;
                ymax_r <= in_point_y;
              end else begin
                ex0_r <= prev_x_r;
                ey0_r <= prev_y_r;
                ex1_r <= in_point_x;
                ey1_r <= in_point_y;
                widx_r <= IW'(loaded_r - 1'b1);
                close_pend_r <= ((loaded_r + 1'b1) == n_eff);
                if (in_point_x < xmin_r) xmin_r <= in_point_x;
                if (in_point_x > xmax_r) xmax_r <= in_point_x;
                if (in_point_y < ymin_r) ymin_r <= in_point_y;
                if (in_point_y > ymax_r) ymax_r <= in_point_y;
              end
            end else if (in_kind == KIND_SPAN) begin
              span_ok_r <= closed && !(in_point_y < ymin_r) && !(in_point_y > ymax_r);
              lft_r <= $signed({{(QW-C-FRAC_BITS){1'b0}}, xmin_r, {FRAC_BITS{1'b0}}});
              rgt_r <= $signed({{(QW-C-FRAC_BITS){1'b0}}, xmax_r, {FRAC_BITS{1'b0}}});
            end
          end
        end
        ST_EMUL2: acc_r <= AW'(mul_r);
        ST_EMUL3: acc_r <= acc_r - AW'(mul_r);
        ST_EWR: begin
          if (close_pend_r) begin
            close_pend_r <= 1'b0;
            ex0_r  <= prev_x_r;
            ey0_r  <= prev_y_r;
            ex1_r  <= first_x_r;
            ey1_r  <= first_y_r;
            widx_r <= IW'(n_eff - 1'b1);
          end
        end
        ST_TMUL2: acc_r <= AW'(mul_r);
        ST_TMUL3: acc_r <= acc_r + AW'(mul_r) + AW'(rd_q.c);
        ST_TCHK: begin
          if (acc_r > 0) outside_r <= 1'b1;
          if (!last_edge) idx_r <= idx_r + 1'b1;
        end
        ST_SMUL1: begin
          if (rd_q.a == '0) begin
            lft_r <= $signed({{(QW-C-FRAC_BITS){1'b0}}, rd_q.lo, {FRAC_BITS{1'b0}}});
            rgt_r <= $signed({{(QW-C-FRAC_BITS){1'b0}}, rd_q.hi, {FRAC_BITS{1'b0}}});
            if (!last_edge) idx_r <= idx_r + 1'b1;
          end
        end
        ST_SMUL2: acc_r <= -AW'(mul_r) - AW'(rd_q.c);
        ST_SDIV: begin
          div_started_r <= 1'b1;
          if (div_done) begin
            div_started_r <= 1'b0;
            if (rd_q.left) begin
              if (div_quo > lft_r) lft_r <= div_quo;
            end else if (div_quo < rgt_r) begin
              rgt_r <= div_quo;
            end
            if (!last_edge) idx_r <= idx_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            res_kind_r   <= mode_r;
            res_inside_r <= (mode_r == KIND_POINT) && !outside_r;
            if (mode_r == KIND_SPAN && span_ok_r && (lft_r < rgt_r)) begin
              res_valid_r <= 1'b1;
              res_left_r  <= $signed({1'b0, lrnd}) - $signed((C+1)'(1));
              res_right_r <= rrnd;
            end else begin
              res_valid_r <= 1'b0;
              res_left_r  <= '0;
              res_right_r <= '0;
            end
          end
        end
        default: ;
      endcase

      if (cfg_valid) begin
        vcount_r <= cfg_vertex_count;
        loaded_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_kind_r;
  assign out_inside_res  = res_inside_r;
  assign out_span_valid  = res_valid_r;
  assign out_span_left   = res_left_r;
  assign out_span_right  = res_right_r;

endmodule
